// ----- rtl/sbcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbcd_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CODE_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = 2'd2;

    localparam logic [CFG_DATA_W-1:0] ON_TICKS_RST    = 16'd200;
    localparam logic [CFG_DATA_W-1:0] OFF_TICKS_RST   = 16'd200;
    localparam logic [CFG_DATA_W-1:0] PAUSE_TICKS_RST = 16'd1200;

    localparam int unsigned WARN_TOP = 5;
    localparam int unsigned ERR_TOP  = 6;

    typedef enum logic [1:0] {
        SRC_NONE    = 2'd0,
        SRC_WARNING = 2'd1,
        SRC_ERROR   = 2'd2
    } t_src;

    typedef struct packed {
        t_src              src;
        logic [CODE_W-1:0] code;
    } t_pick;

endpackage

`default_nettype wire

// ----- rtl/sbcd_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbcd_pick
    import sbcd_pkg::*;
(
    input  wire logic [5:0] i_warning_bits,
    input  wire logic [6:0] i_error_bits,
    output t_pick           o_pick
);

    logic [CODE_W-1:0] w_err_code;
    logic [CODE_W-1:0] w_warn_code;

    // scan from the top down so the lowest set code is the last one kept
    always_comb begin
        w_err_code = '0;
        for (int k = ERR_TOP; k >= 1; k--) begin
            if (i_error_bits[k]) begin
                w_err_code = CODE_W'(k);
            end
        end
    end

    always_comb begin
        w_warn_code = '0;
        for (int k = WARN_TOP; k >= 1; k--) begin
            if (i_warning_bits[k]) begin
                w_warn_code = CODE_W'(k);
            end
        end
    end

    always_comb begin
        if (w_err_code != '0) begin
            o_pick.src  = SRC_ERROR;
            o_pick.code = w_err_code;
        end else if (w_warn_code != '0) begin
            o_pick.src  = SRC_WARNING;
            o_pick.code = w_warn_code;
        end else begin
            o_pick.src  = SRC_NONE;
            o_pick.code = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/status_blink_code_driver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A tick item passes through the input register, then the sequencer update into
//   the result register; a stall on the output holds it in the input register.
// Throughput: one item per cycle unless the output stalls; the sequencer step is a single compare chain.
// Reset (synchronous, active low) clears the sequencer state and both valids
//   and loads the on, off and pause lengths with their default values.

module status_blink_code_driver
    import sbcd_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [5:0]            i_warning_bits,
    input  wire logic [6:0]            i_error_bits,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_warning_led,
    output logic                       o_error_led,
    output logic [CODE_W-1:0]          o_shown_code,
    output logic [1:0]                 o_shown_source
);

    localparam int unsigned CMP_W = (COUNTER_BITS > CFG_DATA_W) ? COUNTER_BITS : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_on_ticks;
    logic [CFG_DATA_W-1:0] r_off_ticks;
    logic [CFG_DATA_W-1:0] r_pause_ticks;

    logic       r_in_valid;
    logic [5:0] r_warning_bits;
    logic [6:0] r_error_bits;
    logic       w_adv;
    logic       w_in_acc;

    logic [COUNTER_BITS-1:0] r_elapsed, n_elapsed;
    logic                    r_lit, n_lit;
    logic                    r_pausing, n_pausing;
    logic [CODE_W-1:0]       r_flashes, n_flashes;
    logic [CODE_W-1:0]       r_code;
    t_src                    r_src;

    logic       r_out_valid;
    logic       r_warning_led;
    logic       r_error_led;
    logic [CODE_W-1:0] r_shown_code;
    t_src       r_shown_src;

    t_pick w_pick;
    logic  w_restart;

    sbcd_pick u_pick (
        .i_warning_bits (r_warning_bits),
        .i_error_bits   (r_error_bits),
        .o_pick         (w_pick)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks    <= ON_TICKS_RST;
            r_off_ticks   <= OFF_TICKS_RST;
            r_pause_ticks <= PAUSE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ON_TICKS:    r_on_ticks    <= i_cfg_data;
                CFG_OFF_TICKS:   r_off_ticks   <= i_cfg_data;
                CFG_PAUSE_TICKS: r_pause_ticks <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // handshake: the input register drains whenever the result register can take
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_warning_bits <= i_warning_bits;
            r_error_bits   <= i_error_bits;
        end
    end

    // one tick of the blink sequencer
    always_comb begin
        logic [COUNTER_BITS-1:0] v_e;
        logic                    v_proceed;

        w_restart = (w_pick.src != r_src) || (w_pick.code != r_code);
        if (w_restart) begin
            v_e       = '0;
            n_lit     = 1'b0;
            n_pausing = 1'b0;
            n_flashes = w_pick.code;
        end else begin
            v_e       = (&r_elapsed) ? r_elapsed : r_elapsed + COUNTER_BITS'(1);
            n_lit     = r_lit;
            n_pausing = r_pausing;
            n_flashes = r_flashes;
        end

        v_proceed = 1'b1;
        if (w_pick.code != '0) begin
            if (n_pausing) begin
                if (CMP_W'(v_e) >= CMP_W'(r_pause_ticks)) begin
                    // start the next group on this tick
                    n_pausing = 1'b0;
                    n_flashes = w_pick.code;
                    v_e       = '0;
                end else begin
                    v_proceed = 1'b0;
                end
            end
            if (v_proceed) begin
                if (!n_lit) begin
                    if (n_flashes != '0 && CMP_W'(v_e) >= CMP_W'(r_off_ticks)) begin
                        n_lit = 1'b1;
                        v_e   = '0;
                    end
                end else if (CMP_W'(v_e) >= CMP_W'(r_on_ticks)) begin
                    n_lit = 1'b0;
                    if (n_flashes != '0) begin
                        n_flashes = n_flashes - CODE_W'(1);
                    end
                    v_e = '0;
                    if (n_flashes == '0) begin
                        n_pausing = 1'b1;
                    end
                end
            end
        end else begin
            n_lit = 1'b0;
        end
        n_elapsed = v_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_lit     <= 1'b0;
            r_pausing <= 1'b0;
            r_flashes <= '0;
            r_code    <= '0;
            r_src     <= SRC_NONE;
        end else if (w_adv) begin
            r_elapsed <= n_elapsed;
            r_lit     <= n_lit;
            r_pausing <= n_pausing;
            r_flashes <= n_flashes;
            r_code    <= w_pick.code;
            r_src     <= w_pick.src;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_warning_led <= n_lit && (w_pick.src == SRC_WARNING);
            r_error_led   <= n_lit && (w_pick.src == SRC_ERROR);
            r_shown_code  <= w_pick.code;
            r_shown_src   <= w_pick.src;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_warning_led  = r_warning_led;
    assign o_error_led    = r_error_led;
    assign o_shown_code   = r_shown_code;
    assign o_shown_source = r_shown_src;

`ifndef SYNTHESIS
    a_one_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_warning_led && o_error_led))
        else $error("both LEDs lit");

    a_none_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_shown_source == SRC_NONE) |->
            (o_shown_code == '0 && !o_warning_led && !o_error_led))
        else $error("no source but code or LED shown");

    a_flashes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flashes <= r_code)
        else $error("flash count exceeds code");

    a_hold_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result is blocked");

    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_adv) && !$past(w_restart) && $past(&r_elapsed)
            && !$past(n_lit != r_lit) && !$past(n_pausing != r_pausing))
            |-> (&r_elapsed))
        else $error("tick counter wrapped");
`endif

endmodule

`default_nettype wire
